/* rtl/lcd_timing_stat_controller_macros.svh */
// assertion macros for the lcd timing and stat controller
`ifndef LCD_TIMING_STAT_CONTROLLER_MACROS_SVH
`define LCD_TIMING_STAT_CONTROLLER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define LTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define LTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lts_pkg.sv */
// shared types and constants of the lcd timing and stat controller
package lts_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_ACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_SCY  = 16'hFF42;
    localparam logic [15:0] ADDR_SCX  = 16'hFF43;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_LYC  = 16'hFF45;
    localparam logic [15:0] ADDR_BGP  = 16'hFF47;

    localparam logic [8:0] SCAN_DOTS   = 9'd80;
    localparam logic [8:0] XFER_END    = 9'd252;   // scan plus 172 transfer dots
    localparam logic [8:0] STEP_DOTS   = 9'd4;
    localparam int         LCD_ON_BIT  = 7;
    localparam logic [7:0] UNDECODED   = 8'hFF;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // register write request
    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_reg_wr;

    // register state seen by the timing logic
    typedef struct packed {
        logic       lcd_on;
        logic       lcd_off;   // this write turns the lcd off
        logic [3:0] stat_en;
        logic [7:0] lyc;
    } t_reg_view;

    // outcome of one 4-dot step
    typedef struct packed {
        logic [8:0] dot;
        logic [7:0] line;
        t_mode      mode;
        logic       level;
        logic       stat_rise;
        logic       blank_hit;
    } t_step_res;

    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input logic [7:0] rd,
        input logic       vbl,
        input logic       stat,
        input logic       frame,
        input t_mode      mode,
        input logic [7:0] line
    );
        pack_result = {3'b000, line, mode, frame, stat, vbl, rd};
    endfunction

endpackage

/* rtl/lts_step.sv */
// one 4-dot step of the dot and line counters, mode and stat line
module lts_step #(
    parameter int DOTS_LINE        = 456,
    parameter int LINES_FRAME      = 154,
    parameter int FIRST_BLANK_LINE = 144
) (
    input  logic [8:0]        i_dot,
    input  logic [7:0]        i_line,
    input  logic              i_prev,
    input  lts_pkg::t_reg_view i_view,
    output lts_pkg::t_step_res o_res
);
    import lts_pkg::*;

    localparam logic [8:0] DotsLine   = 9'(DOTS_LINE);
    localparam logic [8:0] LinesFrame = 9'(LINES_FRAME);
    localparam logic [7:0] FirstBlank = 8'(FIRST_BLANK_LINE);

    logic [8:0] dot_sum;
    logic [8:0] line_inc;
    logic [8:0] dot_new;
    logic [7:0] line_new;
    t_mode      mode_new;
    logic       level;

    always_comb begin
        dot_sum  = i_dot + STEP_DOTS;
        line_inc = {1'b0, i_line} + 9'd1;
        if (dot_sum >= DotsLine) begin
            dot_new  = dot_sum - DotsLine;
            line_new = (line_inc == LinesFrame) ? 8'd0 : line_inc[7:0];
        end else begin
            dot_new  = dot_sum;
            line_new = i_line;
        end

        if (line_new >= FirstBlank) begin
            mode_new = MODE_VBLANK;
        end else if (dot_new < SCAN_DOTS) begin
            mode_new = MODE_OAM;
        end else if (dot_new < XFER_END) begin
            mode_new = MODE_XFER;
        end else begin
            mode_new = MODE_HBLANK;
        end

        level = (i_view.stat_en[3] && (line_new == i_view.lyc)) ||
                (i_view.stat_en[2] && (mode_new == MODE_OAM)) ||
                (i_view.stat_en[1] && (mode_new == MODE_VBLANK)) ||
                (i_view.stat_en[0] && (mode_new == MODE_HBLANK));

        o_res.dot       = dot_new;
        o_res.line      = line_new;
        o_res.mode      = mode_new;
        o_res.level     = level;
        o_res.stat_rise = level && !i_prev;
        o_res.blank_hit = (dot_sum >= DotsLine) && (line_new == FirstBlank);
    end

endmodule

/* rtl/lts_regs.sv */
// lcd control, stat enable, scroll, compare and palette registers
module lts_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lts_pkg::t_reg_wr   i_wr,
    input  logic [15:0]        i_rd_addr,
    input  logic [7:0]         i_line,
    input  lts_pkg::t_mode     i_mode,
    output lts_pkg::t_reg_view o_view,
    output logic [7:0]         o_rd_data
);
    import lts_pkg::*;

    logic [7:0] r_lcdc;
    logic [3:0] r_stat_en;
    logic [7:0] r_scy;
    logic [7:0] r_scx;
    logic [7:0] r_lyc;
    logic [7:0] r_bgp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc    <= '0;
            r_stat_en <= '0;
            r_scy     <= '0;
            r_scx     <= '0;
            r_lyc     <= '0;
            r_bgp     <= '0;
        end else if (i_wr.we) begin
            case (i_wr.addr)
                ADDR_LCDC: r_lcdc    <= i_wr.data;
                ADDR_STAT: r_stat_en <= i_wr.data[6:3];
                ADDR_SCY:  r_scy     <= i_wr.data;
                ADDR_SCX:  r_scx     <= i_wr.data;
                ADDR_LYC:  r_lyc     <= i_wr.data;
                ADDR_BGP:  r_bgp     <= i_wr.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_view.lcd_on  = r_lcdc[LCD_ON_BIT];
        o_view.lcd_off = i_wr.we && (i_wr.addr == ADDR_LCDC) &&
                         r_lcdc[LCD_ON_BIT] && !i_wr.data[LCD_ON_BIT];
        o_view.stat_en = r_stat_en;
        o_view.lyc     = r_lyc;
    end

    always_comb begin
        case (i_rd_addr)
            ADDR_LCDC: o_rd_data = r_lcdc;
            ADDR_STAT: o_rd_data = {1'b1, r_stat_en, (i_line == r_lyc), i_mode};
            ADDR_SCY:  o_rd_data = r_scy;
            ADDR_SCX:  o_rd_data = r_scx;
            ADDR_LY:   o_rd_data = i_line;
            ADDR_LYC:  o_rd_data = r_lyc;
            ADDR_BGP:  o_rd_data = r_bgp;
            default:   o_rd_data = UNDECODED;
        endcase
    end

endmodule

/* rtl/lcd_timing_stat_controller.sv */
// lcd timing and stat interrupt controller, top level
//
// one input beat carries an operation in s_axis_tuser: tick, register write,
// register read or flag acknowledge. every input beat gives exactly one
// output beat with the read byte, the three interrupt flags, the mode and LY.
// a register write, read or acknowledge puts its result in the output register,
// where it is valid from the cycle after the accepting cycle.
// a tick with the lcd on runs as many 4-dot steps as s_axis_tdata[31:26] gives, through
// the single step unit, one step per clock, and takes no new beat until the last
// step is done; with the lcd off or no whole step, the state is reported unchanged.
// s_axis_tready is high while no tick is stepping and the output register
// is empty or being emptied in the same cycle, so a stalled receiver holds
// the next item back at the input and no result is lost.
// synchronous active-low reset clears counters, registers and flags, and
// leaves the mode at hblank with no output beat pending.
`include "lcd_timing_stat_controller_macros.svh"

module lcd_timing_stat_controller #(
    parameter int DOTS_LINE        = 456,
    parameter int LINES_FRAME      = 154,
    parameter int FIRST_BLANK_LINE = 144
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // reg_address[15:0], write_data[23:16], tick_cycles[31:24], ack_mask[34:32]
    input  logic [lts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  logic [lts_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data[7:0], vblank_pending[8], stat_pending[9], frame_pending[10],
    // lcd_mode[12:11], current_line[20:13]
    output logic [lts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import lts_pkg::*;

    localparam logic [8:0] DotsLine   = 9'(DOTS_LINE);
    localparam logic [7:0] LinesFrame = 8'(LINES_FRAME);

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } t_state;

    // input beat fields
    t_op        in_op;
    logic [15:0] in_addr;
    logic [7:0] in_data;
    logic [5:0] in_steps;
    logic [2:0] in_ack;

    t_state     r_state, n_state;
    logic [5:0] r_steps, n_steps;
    logic [8:0] r_dot, n_dot;
    logic [7:0] r_line, n_line;
    t_mode      r_mode, n_mode;
    logic       r_prev, n_prev;
    logic       r_vbl, n_vbl;
    logic       r_stat, n_stat;
    logic       r_frame, n_frame;
    logic       r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;

    logic       in_acc;
    t_reg_wr    reg_wr;
    t_reg_view  reg_view;
    logic [7:0] rd_data;
    t_step_res  step_res;

    assign in_op    = t_op'(s_axis_tuser);
    assign in_addr  = s_axis_tdata[15:0];
    assign in_data  = s_axis_tdata[23:16];
    assign in_steps = s_axis_tdata[31:26];   // tick cycles over four
    assign in_ack   = s_axis_tdata[34:32];

    // take a beat only with no tick in flight and room in the output register
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_m_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_comb begin
        reg_wr.we   = in_acc && (in_op == OP_WRITE);
        reg_wr.addr = in_addr;
        reg_wr.data = in_data;
    end

    lts_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (reg_wr),
        .i_rd_addr (in_addr),
        .i_line    (r_line),
        .i_mode    (r_mode),
        .o_view    (reg_view),
        .o_rd_data (rd_data)
    );

    // shared step unit, used once per clock while a tick runs
    lts_step #(
        .DOTS_LINE        (DOTS_LINE),
        .LINES_FRAME      (LINES_FRAME),
        .FIRST_BLANK_LINE (FIRST_BLANK_LINE)
    ) u_step (
        .i_dot  (r_dot),
        .i_line (r_line),
        .i_prev (r_prev),
        .i_view (reg_view),
        .o_res  (step_res)
    );

    always_comb begin
        n_state   = r_state;
        n_steps   = r_steps;
        n_dot     = r_dot;
        n_line    = r_line;
        n_mode    = r_mode;
        n_prev    = r_prev;
        n_vbl     = r_vbl;
        n_stat    = r_stat;
        n_frame   = r_frame;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;

        // output beat taken by the receiver
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        OP_TICK: begin
                            if (reg_view.lcd_on && (in_steps != 6'd0)) begin
                                n_state = ST_STEP;
                                n_steps = in_steps;
                            end else begin
                                // nothing moves: report the state as it is
                                n_m_valid = 1'b1;
                                n_m_data  = pack_result(8'd0, r_vbl, r_stat, r_frame,
                                                        r_mode, r_line);
                            end
                        end
                        OP_WRITE: begin
                            if (reg_view.lcd_off) begin
                                n_dot  = '0;
                                n_line = '0;
                                n_mode = MODE_HBLANK;
                            end
                            n_m_valid = 1'b1;
                            n_m_data  = pack_result(8'd0, r_vbl, r_stat, r_frame,
                                                    n_mode, n_line);
                        end
                        OP_READ: begin
                            n_m_valid = 1'b1;
                            n_m_data  = pack_result(rd_data, r_vbl, r_stat, r_frame,
                                                    r_mode, r_line);
                        end
                        OP_ACK: begin
                            // flags reported before the masked clear
                            n_m_valid = 1'b1;
                            n_m_data  = pack_result(8'd0, r_vbl, r_stat, r_frame,
                                                    r_mode, r_line);
                            if (in_ack[0]) n_vbl   = 1'b0;
                            if (in_ack[1]) n_stat  = 1'b0;
                            if (in_ack[2]) n_frame = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_STEP: begin
                n_dot   = step_res.dot;
                n_line  = step_res.line;
                n_mode  = step_res.mode;
                n_prev  = step_res.level;
                n_vbl   = r_vbl   || step_res.blank_hit;
                n_frame = r_frame || step_res.blank_hit;
                n_stat  = r_stat  || step_res.stat_rise;
                n_steps = r_steps - 6'd1;
                // last step: result goes out with the advanced state
                if (r_steps == 6'd1) begin
                    n_state   = ST_IDLE;
                    n_m_valid = 1'b1;
                    n_m_data  = pack_result(8'd0, n_vbl, n_stat, n_frame,
                                            n_mode, n_line);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_steps   <= '0;
            r_dot     <= '0;
            r_line    <= '0;
            r_mode    <= MODE_HBLANK;
            r_prev    <= 1'b0;
            r_vbl     <= 1'b0;
            r_stat    <= 1'b0;
            r_frame   <= 1'b0;
            r_m_valid <= 1'b0;
            r_m_data  <= '0;
        end else begin
            r_state   <= n_state;
            r_steps   <= n_steps;
            r_dot     <= n_dot;
            r_line    <= n_line;
            r_mode    <= n_mode;
            r_prev    <= n_prev;
            r_vbl     <= n_vbl;
            r_stat    <= n_stat;
            r_frame   <= n_frame;
            r_m_valid <= n_m_valid;
            r_m_data  <= n_m_data;
        end
    end

    `LTS_ASSERT_NOW(a_busy_not_ready, i_clk, i_rst_n, (r_state == ST_STEP), !s_axis_tready, "input taken while a tick is stepping")
    `LTS_ASSERT_NEXT(a_last_step_out, i_clk, i_rst_n, ((r_state == ST_STEP) && (r_steps == 6'd1)), (m_axis_tvalid && (r_state == ST_IDLE)), "last step gave no output beat")
    `LTS_ASSERT_NOW(a_step_count_live, i_clk, i_rst_n, (r_state == ST_STEP), (r_steps != 6'd0), "stepping with no steps left")
    `LTS_ASSERT_NOW(a_counters_in_range, i_clk, i_rst_n, 1'b1, ((r_dot < DotsLine) && (r_line < LinesFrame)), "dot or line counter out of range")

endmodule
